### rtl/core/hmp_pkg.sv
package hmp_pkg;

    localparam int MapNodesDefault = 256;
    localparam int MidDepth        = 4;
    localparam int ResDepth        = 4;
    localparam int CordicSteps     = 14;
    localparam int TaylorTerms     = 12;
    localparam int MoveThresh      = 16384;
    localparam int ClampQ10        = 20480;

    localparam logic signed [17:0] PiQ13     = 18'sd25736;
    localparam logic signed [17:0] HalfPiQ13 = 18'sd12868;
    localparam logic signed [17:0] TwoPiQ13  = 18'sd51472;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_EVAL = 1'b1
    } kind_t;

    typedef enum logic {
        REG_INV_SIGMA_SQ = 1'b0,
        REG_WEIGHT       = 1'b1
    } cfg_reg_t;

    // evaluate request after the node lookup
    typedef struct packed {
        logic               move;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [15:0] meas;
    } mid_item_t;

    typedef struct packed {
        logic signed [15:0] potential;
        logic signed [18:0] weighted_potential;
    } result_t;

    // atan(2^-i) in Q3.13
    function automatic logic [12:0] atan_q13(input int unsigned i);
        logic [12:0] a;
        case (i)
            0:       a = 13'd6434;
            1:       a = 13'd3798;
            2:       a = 13'd2007;
            3:       a = 13'd1019;
            4:       a = 13'd511;
            5:       a = 13'd256;
            6:       a = 13'd128;
            7:       a = 13'd64;
            8:       a = 13'd32;
            9:       a = 13'd16;
            10:      a = 13'd8;
            11:      a = 13'd4;
            12:      a = 13'd2;
            13:      a = 13'd1;
            default: a = 13'd0;
        endcase
        return a;
    endfunction

endpackage

### rtl/core/hmp_fifo.sv
module hmp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !full)
        else $error("write into full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_rd && !do_wr) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count lost a read");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a write");
`endif
endmodule

### rtl/core/hmp_front.sv
module hmp_front #(
    parameter int MAP_NODES = hmp_pkg::MapNodesDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               kind,
    input  logic [7:0]         loc_a,
    input  logic [7:0]         loc_b,
    input  logic signed [15:0] x_pos,
    input  logic signed [15:0] y_pos,
    input  logic signed [15:0] orient_meas,
    output logic               mid_push,
    output hmp_pkg::mid_item_t mid_item,
    input  logic               mid_full
);
    import hmp_pkg::*;

    localparam int AW = (MAP_NODES > 1) ? $clog2(MAP_NODES) : 1;

    logic [31:0]        node_mem [0:MAP_NODES-1];
    logic               adv, accept, a_in, b_in;
    logic               v1_reg, v2_reg, v3_reg;
    logic [31:0]        rd_a_reg, rd_b_reg;
    logic               a_ok_reg, b_ok_reg;
    logic signed [15:0] meas1_reg, meas2_reg, meas3_reg;
    logic signed [15:0] xa, ya, xb, yb;
    logic signed [16:0] dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic [33:0]        sqx_reg, sqy_reg;

    assign adv    = !(v3_reg && mid_full);
    assign full   = !adv;
    assign accept = push && adv;
    assign a_in   = (32'(loc_a) < 32'(MAP_NODES));
    assign b_in   = (32'(loc_b) < 32'(MAP_NODES));

    // node store: written on load, two registered lookups on evaluate
    always_ff @(posedge clk)
    begin
        if (accept && kind_t'(kind) == KIND_LOAD && a_in)
        begin
            node_mem[AW'(loc_a)] <= {x_pos, y_pos};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_a_reg <= node_mem[AW'(loc_a)];
            rd_b_reg <= node_mem[AW'(loc_b)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= accept && kind_t'(kind) == KIND_EVAL;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // out-of-range nodes read as the origin
    assign xa = a_ok_reg ? $signed(rd_a_reg[31:16]) : 16'sd0;
    assign ya = a_ok_reg ? $signed(rd_a_reg[15:0])  : 16'sd0;
    assign xb = b_ok_reg ? $signed(rd_b_reg[31:16]) : 16'sd0;
    assign yb = b_ok_reg ? $signed(rd_b_reg[15:0])  : 16'sd0;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ok_reg  <= a_in;
            b_ok_reg  <= b_in;
            meas1_reg <= orient_meas;
            dx2_reg   <= 17'(xb) - 17'(xa);
            dy2_reg   <= 17'(yb) - 17'(ya);
            meas2_reg <= meas1_reg;
            sqx_reg   <= 34'(dx2_reg) * 34'(dx2_reg);
            sqy_reg   <= 34'(dy2_reg) * 34'(dy2_reg);
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
            meas3_reg <= meas2_reg;
        end
    end

    assign mid_push      = v3_reg && !mid_full;
    assign mid_item.move = (35'(sqx_reg) + 35'(sqy_reg)) > 35'(MoveThresh);
    assign mid_item.dx   = dx3_reg;
    assign mid_item.dy   = dy3_reg;
    assign mid_item.meas = meas3_reg;
endmodule

### rtl/core/hmp_back.sv
module hmp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mid_empty,
    input  hmp_pkg::mid_item_t mid_item,
    output logic               mid_pop,
    input  logic [15:0]        inv_sigma_sq,
    input  logic signed [15:0] weight,
    input  logic               res_full,
    output logic               res_push,
    output hmp_pkg::result_t   res_item
);
    import hmp_pkg::*;

    localparam int NT   = TaylorTerms - 1;
    localparam int NSTG = 1 + CordicSteps + 3 + 3 * NT + 4;

    logic            adv;
    logic [NSTG-1:0] vld_reg;

    assign adv      = !(vld_reg[NSTG-1] && res_full);
    assign mid_pop  = !mid_empty && adv;
    assign res_push = vld_reg[NSTG-1] && !res_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], mid_pop};
        end
    end

    // cordic vectoring
    logic signed [31:0] cx_reg [0:CordicSteps];
    logic signed [31:0] cy_reg [0:CordicSteps];
    logic signed [16:0] cz_reg [0:CordicSteps];
    logic               cm_reg [0:CordicSteps];
    logic signed [15:0] cmeas_reg [0:CordicSteps];
    logic               neg;
    logic signed [17:0] x0, y0;
    logic signed [16:0] z0;

    assign neg = mid_item.dx < 0;
    assign x0  = neg ? -18'(mid_item.dx) : 18'(mid_item.dx);
    assign y0  = neg ? -18'(mid_item.dy) : 18'(mid_item.dy);
    assign z0  = !neg ? 17'sd0 : (mid_item.dy >= 0 ? 17'(PiQ13) : -17'(PiQ13));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[0]    <= 32'(x0) <<< 12;
            cy_reg[0]    <= 32'(y0) <<< 12;
            cz_reg[0]    <= z0;
            cm_reg[0]    <= mid_item.move;
            cmeas_reg[0] <= mid_item.meas;
        end
    end

    for (genvar i = 0; i < CordicSteps; i++)
    begin : g_cordic
        localparam logic signed [16:0] Ang = $signed({4'b0, atan_q13(i)});
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (cy_reg[i] >= 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + Ang;
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - Ang;
                end
                cm_reg[i+1]    <= cm_reg[i];
                cmeas_reg[i+1] <= cmeas_reg[i];
            end
        end
    end

    // heading error wrap, then exponent argument
    logic signed [17:0] err_raw, err_w1, err_w2, err_reg, e_first_reg;

    assign err_raw = 18'(cz_reg[CordicSteps]) - 18'(cmeas_reg[CordicSteps]);
    assign err_w1  = (err_raw > PiQ13) ? err_raw - TwoPiQ13 : err_raw;
    assign err_w2  = (err_w1 < -PiQ13) ? err_w1 + TwoPiQ13 : err_w1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err_reg     <= cm_reg[CordicSteps] ? err_w2 : 18'sd0;
            e_first_reg <= ((err_reg < 0) ? -err_reg : err_reg) - HalfPiQ13;
        end
    end

    // taylor series in Q30
    logic signed [34:0] tt_reg  [0:NT];
    logic signed [35:0] sum_reg [0:NT];
    logic signed [17:0] ee_reg  [0:NT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tt_reg[0]  <= 35'(e_first_reg) <<< 17;
            sum_reg[0] <= 36'sd1073741824 + (36'(e_first_reg) <<< 17);
            ee_reg[0]  <= e_first_reg;
        end
    end

    for (genvar k = 0; k < NT; k++)
    begin : g_term
        localparam int          N     = k + 2;
        localparam logic [33:0] Recip = 34'((64'd1 << 34) / N);

        logic signed [52:0] prod;
        logic [52:0]        prod_abs;
        logic [33:0]        amag_reg, bmag_reg, q0_reg, rem;
        logic               sgn_reg, sgnb_reg;
        logic signed [35:0] suma_reg, sumb_reg;
        logic signed [17:0] ea_reg, eb_reg;
        logic [67:0]        qprod;
        logic [33:0]        q;

        assign prod     = 53'(tt_reg[k]) * 53'(ee_reg[k]);
        assign prod_abs = (prod < 0) ? 53'(-prod) : 53'(prod);
        assign qprod    = 68'(amag_reg) * 68'(Recip);
        assign rem      = bmag_reg - 34'(q0_reg * 34'(N));
        assign q        = q0_reg + 34'(rem >= 34'(N));

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                amag_reg  <= prod_abs[46:13];
                sgn_reg   <= prod < 0;
                suma_reg  <= sum_reg[k];
                ea_reg    <= ee_reg[k];
                q0_reg    <= qprod[67:34];
                bmag_reg  <= amag_reg;
                sgnb_reg  <= sgn_reg;
                sumb_reg  <= suma_reg;
                eb_reg    <= ea_reg;
                tt_reg[k+1]  <= sgnb_reg ? -35'(q) : 35'(q);
                sum_reg[k+1] <= sumb_reg + (sgnb_reg ? -36'(q) : 36'(q));
                ee_reg[k+1]  <= eb_reg;
            end
        end
    end

    // scale, round, clamp, weight
    logic [49:0]        scl_reg;
    logic [21:0]        mag;
    logic signed [15:0] pot_reg, pot2_reg, pot3_reg;
    logic signed [31:0] wprod_reg;
    logic signed [31:0] wround;
    logic signed [18:0] wp_reg;
    logic [33:0]        exu;

    assign exu    = (sum_reg[NT] < 0) ? 34'd0 : sum_reg[NT][33:0];
    assign mag    = 22'((scl_reg + 50'd134217728) >> 28);
    assign wround = (wprod_reg + 32'sd2048) >>> 12;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            scl_reg   <= 50'(exu) * 50'(inv_sigma_sq);
            pot_reg   <= (mag > 22'(ClampQ10)) ? -16'(ClampQ10) : -$signed(16'(mag));
            wprod_reg <= 32'(pot_reg) * 32'(weight);
            pot2_reg  <= pot_reg;
            wp_reg    <= wround[18:0];
            pot3_reg  <= pot2_reg;
        end
    end

    assign res_item.potential          = pot3_reg;
    assign res_item.weighted_potential = wp_reg;
endmodule

### rtl/core/heading_move_potential.sv
// an accepted evaluate request gives its result at the result queue head;
// load requests give no result; throughput: one request per cycle while
// full is low, set by the node store (one write port, two read ports)
// and the fully pipelined cordic and taylor stages
// reset: queues and pipeline valids clear, inv_sigma_sq = 1.0, weight = 1.0;
// the node store holds no defined value until loaded
module heading_move_potential #(
    parameter int MAP_NODES = hmp_pkg::MapNodesDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    // request side
    input  logic               push,
    output logic               full,
    input  logic               kind,
    input  logic [7:0]         loc_a,
    input  logic [7:0]         loc_b,
    input  logic signed [15:0] x_pos,
    input  logic signed [15:0] y_pos,
    input  logic signed [15:0] orient_meas,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] potential,
    output logic signed [18:0] weighted_potential,
    // configuration
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);
    import hmp_pkg::*;

    logic [15:0]        inv_sigma_sq_reg;
    logic signed [15:0] weight_reg;

    // config registers, to be written only while idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_sigma_sq_reg <= 16'd256;
            weight_reg       <= 16'sd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_INV_SIGMA_SQ: inv_sigma_sq_reg <= cfg_data;
                REG_WEIGHT:       weight_reg       <= $signed(cfg_data);
                default:          ;
            endcase
        end
    end

    // front: node store, displacement and movement test
    logic      mid_push, mid_full, mid_pop, mid_empty;
    mid_item_t mid_in, mid_head;
    logic [$bits(mid_item_t)-1:0] mid_rd;

    hmp_front #(
        .MAP_NODES (MAP_NODES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .loc_a       (loc_a),
        .loc_b       (loc_b),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .orient_meas (orient_meas),
        .mid_push    (mid_push),
        .mid_item    (mid_in),
        .mid_full    (mid_full)
    );

    // short queue decoupling front and back stalls
    hmp_fifo #(
        .WIDTH ($bits(mid_item_t)),
        .DEPTH (MidDepth)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data (mid_in),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_data (mid_rd),
        .empty   (mid_empty)
    );

    assign mid_head = mid_item_t'(mid_rd);

    // back: cordic heading, wrap, exp series, scaling
    logic    res_push, res_full;
    result_t res_in, res_head;
    logic [$bits(result_t)-1:0] res_rd;

    hmp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .mid_empty    (mid_empty),
        .mid_item     (mid_head),
        .mid_pop      (mid_pop),
        .inv_sigma_sq (inv_sigma_sq_reg),
        .weight       (weight_reg),
        .res_full     (res_full),
        .res_push     (res_push),
        .res_item     (res_in)
    );

    // result queue, its head drives the result ports
    hmp_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (ResDepth)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign res_head           = result_t'(res_rd);
    assign potential          = res_head.potential;
    assign weighted_potential = res_head.weighted_potential;
endmodule

### dv/heading_move_potential_tb.sv
module heading_move_potential_tb;
    import hmp_pkg::*;

    localparam int NODES      = 256;
    localparam int LATENCY    = 59;
    localparam int CYCLE_MAX  = 900000;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         loc_a;
        logic [7:0]         loc_b;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic signed [15:0] orient_meas;
    } request_t;

    typedef struct {
        logic signed [15:0] potential;
        logic signed [18:0] weighted_potential;
    } potential_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               kind = 1'b0;
    logic [7:0]         loc_a = '0;
    logic [7:0]         loc_b = '0;
    logic signed [15:0] x_pos = '0;
    logic signed [15:0] y_pos = '0;
    logic signed [15:0] orient_meas = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [15:0] potential;
    logic signed [18:0] weighted_potential;
    logic               cfg_we = 1'b0;
    logic               cfg_index = 1'b0;
    logic [15:0]        cfg_data = '0;

    heading_move_potential DUT (.*);

    // clock, period 8
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state: node store and registers
    logic signed [15:0] pos_x [NODES];
    logic signed [15:0] pos_y [NODES];
    bit                 loaded [NODES];
    logic [15:0]        inv_sigma_sq_q;
    logic signed [15:0] weight_q;

    request_t   request_queue[$];
    potential_t expected_potentials[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         driver_hold = 0;
    int         pop_hold = 0;
    bit         sender_paused = 1'b0;

    function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    // cordic vectoring heading of (dx, dy) in Q3.13
    function automatic longint cordic_heading(longint dx, longint dy);
        longint x, y, z, xs, ys;
        longint steps [14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
        x = dx;
        y = dy;
        z = 0;
        if (dx < 0)
        begin
            x = -dx;
            y = -dy;
            z = (dy >= 0) ? 25736 : -25736;
        end
        x = x * 4096;
        y = y * 4096;
        for (int i = 0; i < 14; i++)
        begin
            xs = shift_floor(x, i);
            ys = shift_floor(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += steps[i];
            end
            else
            begin
                x -= ys; y += xs; z -= steps[i];
            end
        end
        return z;
    endfunction

    // heading error to potential pair
    function automatic potential_t predict_potential(request_t r);
        potential_t res;
        longint x1, y1, x2, y2, dx, dy, err, e, term, sum, mag, pot;
        x1 = 0; y1 = 0; x2 = 0; y2 = 0; err = 0;
        x1 = pos_x[r.loc_a]; y1 = pos_y[r.loc_a];
        x2 = pos_x[r.loc_b]; y2 = pos_y[r.loc_b];
        dx = x2 - x1;
        dy = y2 - y1;
        if (dx * dx + dy * dy > 16384)
        begin
            err = cordic_heading(dx, dy) - longint'(r.orient_meas);
            if (err > 25736)
                err -= 51472;
            if (err < -25736)
                err += 51472;
        end
        e = (err < 0 ? -err : err) - 12868;
        term = 64'sd1 << 30;
        sum = term;
        for (int n = 1; n <= 12; n++)
        begin
            term = (term * e) / (8192 * n);
            sum += term;
        end
        if (sum < 0)
            sum = 0;
        mag = (sum * longint'(inv_sigma_sq_q) + (64'sd1 << 27)) >>> 28;
        if (mag > 20480)
            mag = 20480;
        pot = -mag;
        res.potential = 16'(pot);
        res.weighted_potential = 19'((pot * longint'(weight_q) + 2048) >>> 12);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
        error_count++;
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [15:0] random_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 2047)) - 1024);
        endcase
    endfunction

    function automatic request_t load_request(int node, logic signed [15:0] x,
                                              logic signed [15:0] y);
        request_t r;
        r.kind = KIND_LOAD;
        r.loc_a = 8'(node);
        r.loc_b = 8'($urandom);
        r.x_pos = x;
        r.y_pos = y;
        r.orient_meas = 16'($urandom);
        loaded[node] = 1'b1;
        return r;
    endfunction

    function automatic request_t eval_request(int a, int b, logic signed [15:0] meas);
        request_t r;
        r.kind = KIND_EVAL;
        r.loc_a = 8'(a);
        r.loc_b = 8'(b);
        r.x_pos = 16'($urandom);
        r.y_pos = 16'($urandom);
        r.orient_meas = meas;
        return r;
    endfunction

    function automatic int loaded_node();
        int n;
        do
            n = $urandom_range(0, NODES - 1);
        while (!loaded[n]);
        return n;
    endfunction

    function automatic logic signed [15:0] random_meas();
        case ($urandom_range(0, 7))
            0: return 16'($urandom);
            1: return 16'sd25736;
            2: return -16'sd25736;
            default: return 16'($signed($urandom_range(0, 51472)) - 25736);
        endcase
    endfunction

    // driver: takes pending requests, updates the predictor on acceptance
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (push && !full)
            begin
                request_t r;
                r = request_queue.pop_front();
                if (r.kind == KIND_LOAD)
                begin
                    pos_x[r.loc_a] = r.x_pos;
                    pos_y[r.loc_a] = r.y_pos;
                end
                else
                    expected_potentials.push_back(predict_potential(r));
            end
            if (push && !full || !push)
            begin
                if (driver_hold > 0)
                begin
                    driver_hold <= driver_hold - 1;
                    push <= 1'b0;
                end
                else if (request_queue.size() > 0 && !sender_paused)
                begin
                    request_t nx;
                    nx = request_queue[0];
                    push <= 1'b1;
                    kind <= nx.kind;
                    loc_a <= nx.loc_a;
                    loc_b <= nx.loc_b;
                    x_pos <= nx.x_pos;
                    y_pos <= nx.y_pos;
                    orient_meas <= nx.orient_meas;
                    driver_hold <= random_gap();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor: random pop stalls, field compare against oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_potentials.size() == 0)
                begin
                    $display("unexpected result potential=%0d (t=%0t)", potential, $time);
                    error_count++;
                end
                else
                begin
                    potential_t want;
                    want = expected_potentials.pop_front();
                    if (potential !== want.potential)
                        report_mismatch("potential", potential, want.potential);
                    if (weighted_potential !== want.weighted_potential)
                        report_mismatch("weighted_potential", weighted_potential,
                                        want.weighted_potential);
                end
            end
            if (pop_hold > 0)
            begin
                pop_hold <= pop_hold - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                pop_hold <= random_gap();
            end
        end
        if (cycle_count > CYCLE_MAX)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic wait_drained();
        while (request_queue.size() > 0 || push)
            @(posedge clk);
        while (expected_potentials.size() > 0)
            @(posedge clk);
        // loads give no result, so let the pipeline settle
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_register(cfg_reg_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_INV_SIGMA_SQ)
            inv_sigma_sq_q = value;
        else
            weight_q = value;
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 25)
                request_queue.push_back(load_request($urandom_range(0, NODES - 1),
                                                     random_coord(), random_coord()));
            else if (r < 35)
            begin
                // short move between neighbors, around the motion threshold
                int a;
                logic signed [15:0] bx;
                a = loaded_node();
                bx = pos_x[a] + 16'($signed($urandom_range(0, 256)) - 128);
                request_queue.push_back(load_request(a ^ 1, bx,
                    pos_y[a] + 16'($signed($urandom_range(0, 256)) - 128)));
                request_queue.push_back(eval_request(a, a ^ 1, random_meas()));
            end
            else
                request_queue.push_back(eval_request(loaded_node(), loaded_node(),
                                                     random_meas()));
        end
    endtask

    initial
    begin
        inv_sigma_sq_q = 16'd256;
        weight_q = 16'sd4096;
        foreach (loaded[i])
        begin
            loaded[i] = 1'b0;
            pos_x[i] = '0;
            pos_y[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every kind, threshold, wrap cases
        request_queue.push_back(load_request(0, 16'sh0000, 16'sh0000));
        request_queue.push_back(load_request(255, 16'sh7fff, 16'sh7fff));
        request_queue.push_back(load_request(1, 16'sh8000, 16'sh8000));
        request_queue.push_back(load_request(2, 16'sd128, 16'sd0));
        request_queue.push_back(load_request(3, 16'sd129, 16'sd0));
        request_queue.push_back(load_request(4, -16'sd256, 16'sd1));
        request_queue.push_back(load_request(5, -16'sd256, -16'sd1));
        request_queue.push_back(eval_request(0, 0, 16'sd0));
        request_queue.push_back(eval_request(0, 2, 16'sd0));
        request_queue.push_back(eval_request(0, 3, 16'sd0));
        request_queue.push_back(eval_request(0, 4, -16'sd25736));
        request_queue.push_back(eval_request(0, 5, 16'sd25736));
        request_queue.push_back(eval_request(1, 255, 16'sh7fff));
        request_queue.push_back(eval_request(255, 1, 16'sh8000));
        request_queue.push_back(eval_request(0, 255, 16'sd6434));
        request_queue.push_back(eval_request(0, 3, 16'sd25736));
        wait_drained();

        write_register(REG_INV_SIGMA_SQ, 16'hffff);
        write_register(REG_WEIGHT, 16'h7fff);
        random_phase(350);
        // sender holds off until all results are in
        sender_paused = 1'b1;
        while (expected_potentials.size() > 0 || push)
            @(posedge clk);
        sender_paused = 1'b0;
        wait_drained();

        write_register(REG_INV_SIGMA_SQ, 16'h0000);
        write_register(REG_WEIGHT, 16'h8000);
        random_phase(250);
        wait_drained();

        write_register(REG_INV_SIGMA_SQ, 16'd1);
        write_register(REG_WEIGHT, 16'h8000);
        random_phase(350);
        wait_drained();

        write_register(REG_INV_SIGMA_SQ, 16'($urandom));
        write_register(REG_WEIGHT, 16'($urandom));
        random_phase(350);
        wait_drained();

        write_register(REG_INV_SIGMA_SQ, 16'd256);
        write_register(REG_WEIGHT, 16'sd4096);
        random_phase(230);
        wait_drained();

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
